// ===== rtl/core/rqs_pkg.sv =====
package rqs_pkg;

    // command codes
    localparam logic [2:0] CMD_INSERT   = 3'd0;
    localparam logic [2:0] CMD_RM_FIFO  = 3'd1;
    localparam logic [2:0] CMD_RM_PRIO  = 3'd2;
    localparam logic [2:0] CMD_RM_SHORT = 3'd3;
    localparam logic [2:0] CMD_RM_RAND  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOD,
        S_SHIFT,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the input item
        logic scan_init;  // start a min scan
        logic scan_step;  // visit one entry
        logic mod_init;   // start remainder
        logic mod_step;   // one remainder bit
        logic pos_fifo;   // pick oldest entry
        logic pos_mod;    // pick remainder result
        logic ins_step;   // move one entry back (insert)
        logic rm_step;    // move one entry forward (remove)
        logic ins_write;  // write new entry at 0, bump count
        logic rm_done;    // drop count
        logic set_empty;
        logic set_full;
        logic set_ok;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       empty;
        logic       full;
        logic       scan_last;
        logic       mod_last;
        logic       ins_last;
        logic       rm_last;
    } t_sts;

endpackage

// ===== rtl/core/rqs_ctrl.sv =====
module rqs_ctrl
    import rqs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_out_free,
    input  t_sts   i_sts,
    output t_ctl   o_ctl,
    output logic   o_idle,
    output logic   o_done
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SCAN;
            end
            S_SCAN: begin
                // first cycle after load: dispatch or run scan
                case (i_sts.cmd)
                    CMD_INSERT: n_state = i_sts.full ? S_DONE : S_SHIFT;
                    CMD_RM_FIFO: n_state = i_sts.empty ? S_DONE : S_SHIFT;
                    CMD_RM_PRIO, CMD_RM_SHORT: begin
                        if (i_sts.empty || i_sts.scan_last) n_state =
                            i_sts.empty ? S_DONE : S_SHIFT;
                    end
                    CMD_RM_RAND: n_state = i_sts.empty ? S_DONE : S_MOD;
                    default: n_state = S_DONE;
                endcase
            end
            S_MOD: begin
                if (i_sts.mod_last) n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if ((i_sts.cmd == CMD_INSERT && i_sts.ins_last) ||
                    (i_sts.cmd != CMD_INSERT && i_sts.rm_last)) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_ctl = '0;
        o_idle = 1'b0;
        o_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
                o_ctl.load = i_start;
                o_ctl.scan_init = i_start;
                o_ctl.mod_init = i_start;
            end
            S_SCAN: begin
                case (i_sts.cmd)
                    CMD_INSERT: begin
                        o_ctl.set_full = i_sts.full;
                        o_ctl.set_ok = !i_sts.full;
                    end
                    CMD_RM_FIFO: begin
                        o_ctl.set_empty = i_sts.empty;
                        o_ctl.set_ok = !i_sts.empty;
                        o_ctl.pos_fifo = !i_sts.empty;
                    end
                    CMD_RM_PRIO, CMD_RM_SHORT: begin
                        o_ctl.set_empty = i_sts.empty;
                        o_ctl.set_ok = !i_sts.empty;
                        o_ctl.scan_step = !i_sts.empty;
                    end
                    CMD_RM_RAND: begin
                        o_ctl.set_empty = i_sts.empty;
                        o_ctl.set_ok = !i_sts.empty;
                    end
                    default: o_ctl.set_ok = 1'b1;
                endcase
            end
            S_MOD: begin
                o_ctl.mod_step = 1'b1;
                o_ctl.pos_mod = i_sts.mod_last;
            end
            S_SHIFT: begin
                if (i_sts.cmd == CMD_INSERT) begin
                    o_ctl.ins_step = !i_sts.ins_last;
                    o_ctl.ins_write = i_sts.ins_last;
                end else begin
                    o_ctl.rm_step = !i_sts.rm_last;
                    o_ctl.rm_done = i_sts.rm_last;
                end
            end
            S_DONE: o_done = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/rqs_dp.sv =====
module rqs_dp
    import rqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int TIME_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    input  logic [2:0]           i_cmd,
    input  logic [ID_BITS-1:0]   i_pid,
    input  logic [7:0]           i_priority_req,
    input  logic [TIME_BITS-1:0] i_arrival,
    input  logic [15:0]          i_remaining,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [15:0]          i_random_value,
    output t_sts                 o_sts,
    output logic [ID_BITS-1:0]   o_removed_pid,
    output logic [1:0]           o_status,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_occupancy
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RB = 16;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [7:0]           prio;
        logic [TIME_BITS-1:0] start;
        logic [15:0]          rem;
    } t_entry;

    // entry store: one write port, one read port, registered read
    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd;

    logic [CW-1:0]        r_count;
    logic [2:0]           r_cmd;
    t_entry               r_new;
    logic [TIME_BITS-1:0] r_now;
    logic [AW-1:0]        r_pos;      // chosen / moving index
    logic [CW-1:0]        r_idx;      // next scan read index
    logic                 r_rd_vld;   // candidate seeded
    logic [AW-1:0]        r_best;
    logic [15:0]          r_bkey;
    logic [TIME_BITS-1:0] r_bstart;
    logic [RB-1:0]        r_rv;       // remainder dividend shift
    logic [CW-1:0]        r_rmd;      // partial remainder
    logic [4:0]           r_mbit;
    logic [1:0]           r_phase;    // shift: 0 read, 1 write
    logic                 r_pick;     // read data holds the chosen entry
    logic [ID_BITS-1:0]   r_rid;
    logic [1:0]           r_status;

    logic [CW-1:0] n_rmd;
    logic [CW:0]   rmd_sh;
    logic [15:0]   rkey;
    logic          better;
    logic          pos_set;
    logic [AW-1:0] pos_val;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    t_entry        wd;

    // status to controller
    assign o_sts.cmd       = r_cmd;
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == CW'(QUEUE_DEPTH));
    assign o_sts.scan_last = r_rd_vld ? (r_idx == r_count) : (r_count == CW'(1));
    assign o_sts.mod_last  = (r_mbit == 5'(RB - 1));
    assign o_sts.ins_last  = (r_pos == '0) && r_phase == 2'd0;
    assign o_sts.rm_last   = (CW'(r_pos) + CW'(1) >= r_count) && r_phase == 2'd0;

    // key of the entry just read
    assign rkey = (r_cmd == CMD_RM_PRIO) ? {8'd0, r_rd.prio} : r_rd.rem;
    assign better = (r_bkey > rkey || (r_bkey == rkey && r_bstart > r_rd.start))
                    && (r_rd.start >= r_now);

    // remainder step: shift in one dividend bit, subtract count once
    assign rmd_sh = {r_rmd, r_rv[RB-1]};
    assign n_rmd  = (rmd_sh >= {1'b0, r_count}) ? CW'(rmd_sh - {1'b0, r_count})
                                                : CW'(rmd_sh);

    // chosen entry of a remove; read at once so its id is at hand next cycle
    assign pos_set = i_ctl.pos_fifo || i_ctl.pos_mod ||
                     (i_ctl.scan_step && o_sts.scan_last);
    always_comb begin
        if (i_ctl.pos_fifo) pos_val = AW'(r_count - CW'(1));
        else if (i_ctl.pos_mod) pos_val = AW'(n_rmd);
        else if (r_rd_vld && better) pos_val = AW'(r_idx - CW'(1));
        else pos_val = r_best;
    end

    // read address
    always_comb begin
        if (i_ctl.load) rd_addr = '0;
        else if (pos_set) rd_addr = pos_val;
        else if (i_ctl.scan_step) rd_addr = AW'(r_idx);
        else if (r_cmd == CMD_INSERT) rd_addr = r_pos - AW'(1);
        else rd_addr = r_pos + AW'(1);
    end

    // write port
    always_comb begin
        we = 1'b0;
        wa = r_pos;
        wd = r_rd;
        if (i_ctl.ins_write) begin
            we = 1'b1;
            wa = '0;
            wd = r_new;
        end else if ((i_ctl.ins_step || i_ctl.rm_step) && r_phase == 2'd1) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= 2'd0;
            r_pick  <= 1'b0;
        end else begin
            if (i_ctl.load) r_phase <= 2'd0;
            else if (i_ctl.ins_step || i_ctl.rm_step) r_phase <= r_phase ^ 2'd1;
            if (i_ctl.ins_write) r_count <= r_count + CW'(1);
            else if (i_ctl.rm_done) r_count <= r_count - CW'(1);
            r_pick <= pos_set;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_new <= '{id: i_pid, prio: i_priority_req, start: i_arrival,
                       rem: i_remaining};
            r_now <= i_now;
            r_rv  <= i_random_value;
        end
        // moving index
        if (i_ctl.load) r_pos <= AW'(r_count);
        else if (pos_set) r_pos <= pos_val;
        else if (i_ctl.ins_step && r_phase == 2'd1) r_pos <= r_pos - AW'(1);
        else if (i_ctl.rm_step && r_phase == 2'd1) r_pos <= r_pos + AW'(1);
        // min scan: read data holds entry r_idx-1 once seeded
        if (i_ctl.scan_init) begin
            r_idx    <= CW'(1);
            r_rd_vld <= 1'b0;
            r_best   <= '0;
        end else if (i_ctl.scan_step) begin
            r_rd_vld <= 1'b1;
            r_idx    <= r_idx + CW'(1);
            if (!r_rd_vld) begin
                // entry 0 seeds the candidate
                r_bkey   <= rkey;
                r_bstart <= r_rd.start;
            end else if (better) begin
                r_best   <= AW'(r_idx - CW'(1));
                r_bkey   <= rkey;
                r_bstart <= r_rd.start;
            end
        end
        if (i_ctl.mod_init) begin
            r_rmd  <= '0;
            r_mbit <= '0;
        end else if (i_ctl.mod_step) begin
            r_rmd  <= n_rmd;
            r_rv   <= {r_rv[RB-2:0], 1'b0};
            r_mbit <= r_mbit + 5'd1;
        end
        // removed id: taken from the chosen slot before the close-up
        if (i_ctl.load) r_rid <= '0;
        else if (r_pick) r_rid <= r_rd.id;
        if (i_ctl.set_empty) r_status <= ST_EMPTY;
        if (i_ctl.set_full)  r_status <= ST_FULL;
        if (i_ctl.set_ok)    r_status <= ST_OK;
    end

    assign o_removed_pid = r_rid;
    assign o_status      = r_status;
    assign o_occupancy   = r_count;

endmodule

// ===== rtl/core/ready_queue_scheduler_core.sv =====
// Channel | Dir | Handshake                  | Payload
// s_axis  | in  | s_axis_tvalid/tready       | tdata: cmd, pid, priority_req, arrival,
//         |     |                            |        remaining, now, random_value
// m_axis  | out | m_axis_tvalid/tready       | tdata: removed_pid, status, occupancy
//
// One item at a time. An insert moves every entry back by one slot, one entry at a
// time through the store, and writes the new entry at slot 0; a remove closes up the
// entries behind the chosen slot, so a FIFO remove, which takes the last slot, moves
// none. Priority and shortest removes first scan the queue, random removes first run
// a 16-bit bit-serial remainder. Rejected inserts, removes on an empty queue and
// unknown commands skip these steps. The result sits in an output register;
// the next item is taken the cycle after it is handed over. Reset empties the queue.
module ready_queue_scheduler_core
    import rqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int TIME_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[2:0], pid[ID_BITS], priority_req[8], arrival[TIME_BITS],
    // remaining[16], now[TIME_BITS], random_value[16], zero fill
    input  logic [((3+ID_BITS+8+TIME_BITS+16+TIME_BITS+16+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // removed_pid[ID_BITS], status[2], occupancy, zero fill
    output logic [((ID_BITS+2+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int P1 = 3;
    localparam int P2 = P1 + ID_BITS;
    localparam int P3 = P2 + 8;
    localparam int P4 = P3 + TIME_BITS;
    localparam int P5 = P4 + 16;
    localparam int P6 = P5 + TIME_BITS;
    localparam int OW = ((ID_BITS + 2 + CW + 7) / 8) * 8;

    t_ctl ctl;
    t_sts sts;
    logic idle, done;
    logic [ID_BITS-1:0] rid;
    logic [1:0] st;
    logic [CW-1:0] occ;

    assign s_axis_tready = idle;
    assign m_axis_tvalid = done;
    assign m_axis_tdata  = OW'({occ, st, rid});

    rqs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid), .i_out_free(m_axis_tready),
        .i_sts(sts), .o_ctl(ctl), .o_idle(idle), .o_done(done)
    );

    rqs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
        .i_cmd(s_axis_tdata[2:0]),
        .i_pid(s_axis_tdata[P2-1:P1]),
        .i_priority_req(s_axis_tdata[P3-1:P2]),
        .i_arrival(s_axis_tdata[P4-1:P3]),
        .i_remaining(s_axis_tdata[P5-1:P4]),
        .i_now(s_axis_tdata[P6-1:P5]),
        .i_random_value(s_axis_tdata[P6+15:P6]),
        .o_sts(sts), .o_removed_pid(rid), .o_status(st), .o_occupancy(occ)
    );

    // occupancy never exceeds depth
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ <= CW'(QUEUE_DEPTH)) else $error("occupancy overflow");

    // no input taken while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready during result");

    // an empty report comes only with a zero count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && st == ST_EMPTY) |-> occ == '0) else $error("empty with entries");

endmodule

// ===== sim/ready_queue_scheduler_core_test.sv =====
`timescale 1ns / 1ps

module ready_queue_scheduler_core_test;
    import rqs_pkg::*;

    localparam int DEPTH      = 16;
    localparam int IN_W       = 88;
    localparam int OUT_W      = 16;
    localparam int MAX_CYCLES = 400000;
    localparam int N_RANDOM   = 750;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    // cmd[2:0], pid[10:3], priority_req[18:11], arrival[34:19],
    // remaining[50:35], now[66:51], random_value[82:67], zero fill
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    // removed_pid[7:0], status[9:8], occupancy[14:10], zero fill
    logic [OUT_W-1:0] m_axis_tdata;

    typedef struct packed {
        logic [15:0] rnd;
        logic [15:0] now;
        logic [15:0] rem;
        logic [15:0] start;
        logic [7:0]  prio;
        logic [7:0]  pid;
        logic [2:0]  cmd;
    } t_item;

    typedef struct packed {
        logic [4:0] occ;
        logic [1:0] status;
        logic [7:0] pid;
    } t_result;

    // directed row: item plus optional typed-in result
    typedef struct {
        t_item   item;
        bit      known;
        t_result res;
    } t_row;

    // predictor state
    logic [7:0]  q_id   [DEPTH];
    logic [7:0]  q_prio [DEPTH];
    logic [15:0] q_start[DEPTH];
    logic [15:0] q_rem  [DEPTH];
    int          q_count;

    t_result expected_q[$];
    t_row    rows[$];
    int      errors;
    int      cycles;
    int      n_results;
    bit      hold_off;
    bit      no_idle;

    ready_queue_scheduler_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // smallest-key scan; key_sel 0 priority, 1 remaining
    function automatic int pick_min(input bit key_sel, input logic [15:0] now);
        int best;
        logic [15:0] kb, ki;
        best = 0;
        for (int i = 0; i < q_count; i++) begin
            kb = key_sel ? q_rem[best] : {8'd0, q_prio[best]};
            ki = key_sel ? q_rem[i] : {8'd0, q_prio[i]};
            if ((kb > ki || (kb == ki && q_start[best] > q_start[i])) && q_start[i] >= now)
                best = i;
        end
        return best;
    endfunction

    function automatic t_result predict_queue(input t_item it);
        t_result r;
        int pos;
        r = '0;
        if (it.cmd == CMD_INSERT) begin
            if (q_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (int i = q_count; i > 0; i--) begin
                    q_id[i] = q_id[i-1]; q_prio[i] = q_prio[i-1];
                    q_start[i] = q_start[i-1]; q_rem[i] = q_rem[i-1];
                end
                q_id[0] = it.pid; q_prio[0] = it.prio;
                q_start[0] = it.start; q_rem[0] = it.rem;
                q_count++;
                r.status = ST_OK;
            end
        end else if (it.cmd <= CMD_RM_RAND) begin
            if (q_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                case (it.cmd)
                    CMD_RM_FIFO:  pos = q_count - 1;
                    CMD_RM_PRIO:  pos = pick_min(1'b0, it.now);
                    CMD_RM_SHORT: pos = pick_min(1'b1, it.now);
                    default:      pos = int'(it.rnd) % q_count;
                endcase
                r.pid = q_id[pos];
                for (int i = pos; i + 1 < q_count; i++) begin
                    q_id[i] = q_id[i+1]; q_prio[i] = q_prio[i+1];
                    q_start[i] = q_start[i+1]; q_rem[i] = q_rem[i+1];
                end
                q_count--;
                r.status = ST_OK;
            end
        end
        r.occ = q_count[4:0];
        return r;
    endfunction

    function automatic t_item rand_item(input int ins_pct);
        t_item it;
        it.pid   = 8'($urandom);
        it.prio  = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7));
        it.start = 16'($urandom);
        it.rem   = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 15));
        it.now   = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom);
        it.rnd   = 16'($urandom);
        if ($urandom_range(0, 99) < ins_pct) it.cmd = CMD_INSERT;
        else if ($urandom_range(0, 49) == 0) it.cmd = 3'($urandom_range(5, 7));
        else it.cmd = 3'($urandom_range(1, 4));
        return it;
    endfunction

    function automatic t_item mk(input logic [2:0] c, input logic [7:0] p, input logic [7:0] pr,
                                 input logic [15:0] st, input logic [15:0] rm,
                                 input logic [15:0] nw, input logic [15:0] rv);
        t_item it;
        it.cmd = c; it.pid = p; it.prio = pr; it.start = st;
        it.rem = rm; it.now = nw; it.rnd = rv;
        return it;
    endfunction

    task automatic add_row(input t_item it, input bit known, input t_result r);
        t_row rw;
        rw.item = it; rw.known = known; rw.res = r;
        rows.push_back(rw);
    endtask

    // one transfer on the input side, with random gaps
    task automatic send_item(input t_item it, input bit known, input t_result r);
        t_result p;
        while (!no_idle && $urandom_range(0, 99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {5'd0, it};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        p = predict_queue(it);
        if (known && p != r) begin
            $error("directed row: typed %h predicted %h", r, p);
            errors++;
        end
        expected_q.push_back(known ? r : p);
    endtask

    // output side: random stall, one long hold-off on request
    initial begin
        int hold;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                hold = 0;
                m_axis_tready <= 1'b0;
                while (hold < 2000) begin
                    @(posedge i_clk);
                    hold++;
                end
                hold_off = 1'b0;
            end
            m_axis_tready <= no_idle || $urandom_range(0, 99) >= 35;
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[14:0];
            n_results++;
            if (expected_q.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.pid !== want.pid) begin
                    $error("removed_pid expected %0d actual %0d", want.pid, got.pid);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
                if (got.occ !== want.occ) begin
                    $error("occupancy expected %0d actual %0d", want.occ, got.occ);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_result z;
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        errors = 0; cycles = 0; n_results = 0; hold_off = 0; no_idle = 0;
        q_count = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        z = '0;
        add_row(mk(CMD_RM_FIFO, 0, 0, 0, 0, 0, 0), 1, '{5'd0, ST_EMPTY, 8'd0});
        add_row(mk(CMD_RM_PRIO, 0, 0, 0, 0, 16'hffff, 0), 1, '{5'd0, ST_EMPTY, 8'd0});
        add_row(mk(CMD_RM_SHORT, 0, 0, 0, 0, 0, 0), 1, '{5'd0, ST_EMPTY, 8'd0});
        add_row(mk(CMD_RM_RAND, 0, 0, 0, 0, 0, 16'hffff), 1, '{5'd0, ST_EMPTY, 8'd0});
        add_row(mk(3'd7, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff), 1,
                '{5'd0, ST_OK, 8'd0});
        add_row(mk(CMD_INSERT, 8'hff, 8'hff, 16'hffff, 16'hffff, 0, 0), 1,
                '{5'd1, ST_OK, 8'd0});
        add_row(mk(CMD_RM_FIFO, 0, 0, 0, 0, 0, 0), 1, '{5'd0, ST_OK, 8'hff});
        // fill to full, then one rejected insert
        for (int i = 0; i < DEPTH; i++)
            add_row(mk(CMD_INSERT, 8'(i + 1), 8'(i % 3), 16'(i * 7), 16'(40 - i), 0, 0), 0, z);
        add_row(mk(CMD_INSERT, 8'haa, 0, 0, 0, 0, 0), 1, '{5'd16, ST_FULL, 8'd0});
        add_row(mk(CMD_RM_PRIO, 0, 0, 0, 0, 0, 0), 0, z);
        add_row(mk(CMD_RM_PRIO, 0, 0, 0, 0, 16'hffff, 0), 0, z); // nothing eligible
        add_row(mk(CMD_RM_SHORT, 0, 0, 0, 0, 16'd30, 0), 0, z);
        add_row(mk(CMD_RM_RAND, 0, 0, 0, 0, 0, 16'hffff), 0, z);
        add_row(mk(CMD_RM_FIFO, 0, 0, 0, 0, 0, 0), 0, z);
        foreach (rows[k]) send_item(rows[k].item, rows[k].known, rows[k].res);

        // random part: drifting insert mix so the queue swings empty to full
        for (int n = 0; n < N_RANDOM; n++) begin
            no_idle = (n >= 300 && n < 400);
            if (n == 500) hold_off = 1'b1;
            send_item(rand_item(((n / 60) % 2) ? 75 : 30), 0, z);
        end
        s_axis_tvalid <= 1'b0;

        // drain
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("%0d commands of all kinds sent, %0d results checked,", rows.size() + N_RANDOM,
                 n_results);
        $display("queue taken through empty, full and receiver back-pressure");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
